>>> sv/pc_trace_bit_packer_unit_defines.svh
`ifndef PC_TRACE_BIT_PACKER_UNIT_DEFINES_SVH
`define PC_TRACE_BIT_PACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define PCBP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcbp check failed");

// next-cycle implication
`define PCBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcbp check failed");

`endif

>>> sv/pcbp_pkg.sv
package pcbp_pkg;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_SYM   = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	localparam logic [1:0] LEN_NONE = 2'd0;
	localparam logic [1:0] LEN_16   = 2'd1;
	localparam logic [1:0] LEN_31   = 2'd2;

	localparam logic [15:0] TABLE_RESET = 16'h9400;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_SYM   = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  nbits;
		logic [63:0] data;
	} op_t;

endpackage

>>> sv/pcbp_fifo.sv
module pcbp_fifo #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pcbp_pkg::op_t push_op,
	output logic          not_full,
	input  logic          pop,
	output logic          not_empty,
	output pcbp_pkg::op_t pop_op
);
	import pcbp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t            mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign not_full  = (count_q != CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_op    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/pcbp_front.sv
module pcbp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    command,
	input  logic [2:0]    symbol_code,
	input  logic [30:0]   payload_value,
	input  logic [63:0]   first_count,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data,
	input  logic          q_not_full,
	output logic          q_push,
	output pcbp_pkg::op_t q_op
);
	import pcbp_pkg::*;

	logic [15:0] table_q;
	logic [1:0]  len_kind;

	assign cfg_ready = 1'b1;
	assign in_stall  = !q_not_full;
	assign q_push    = in_valid && q_not_full && (command != CMD_NONE);
	assign len_kind  = table_q[{symbol_code, 1'b0} +: 2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_q <= TABLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			table_q <= cfg_data;
		end
	end

	// symbol bits are left-aligned in data
	always_comb begin
		q_op = '0;
		unique case (command)
			CMD_START: begin
				q_op.kind  = OP_START;
				q_op.nbits = 6'd0;
				q_op.data  = first_count;
			end
			CMD_SYM: begin
				q_op.kind = OP_SYM;
				case (len_kind)
					LEN_16: begin
						q_op.nbits = 6'd19;
						q_op.data  = {symbol_code, payload_value[15:0], 45'd0};
					end
					LEN_31: begin
						q_op.nbits = 6'd34;
						q_op.data  = {symbol_code, payload_value, 30'd0};
					end
					default: begin
						q_op.nbits = 6'd3;
						q_op.data  = {symbol_code, 61'd0};
					end
				endcase
			end
			CMD_STOP: begin
				q_op.kind  = OP_STOP;
				q_op.nbits = 6'd0;
				q_op.data  = '0;
			end
			default: begin
				q_op = '0;
			end
		endcase
	end

endmodule

>>> sv/pcbp_back.sv
module pcbp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  pcbp_pkg::op_t q_op,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          last_of_run
);
	import pcbp_pkg::*;

	logic        busy_q;
	logic [63:0] work_q;
	logic [7:0]  total_q;
	logic        fill_q;
	logic [7:0]  partial_q;   // held bits, left-aligned, zeros below
	logic [2:0]  held_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;

	logic        out_free;
	logic        emit;
	logic [63:0] load_work;
	logic [7:0]  load_total;
	logic        load_fill;
	logic [63:0] next_work;
	logic [7:0]  next_total;
	logic        next_last;

	assign out_free    = !out_valid_q || !out_stall;
	assign emit        = busy_q && out_free;
	assign q_pop       = !busy_q && q_not_empty;
	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	always_comb begin
		load_fill = 1'b0;
		unique case (q_op.kind)
			OP_START: begin
				load_work  = q_op.data;
				load_total = 8'd128;
				load_fill  = 1'b1;
			end
			OP_SYM: begin
				load_work  = {partial_q, 56'd0} | (q_op.data >> held_q);
				load_total = {5'd0, held_q} + {2'd0, q_op.nbits};
			end
			default: begin
				load_work  = {partial_q, 56'd0};
				load_total = (held_q != 3'd0) ? 8'd8 : 8'd0;
			end
		endcase
	end

	assign next_work  = {work_q[55:0], {8{fill_q}}};
	assign next_total = total_q - 8'd8;
	assign next_last  = (next_total[7:3] == 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			partial_q   <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (load_total[7:3] == 5'd0) begin
					partial_q <= load_work[63:56] & ~(8'hFF >> load_total[2:0]);
					held_q    <= load_total[2:0];
				end else begin
					busy_q <= 1'b1;
				end
			end else if (emit && next_last) begin
				busy_q    <= 1'b0;
				partial_q <= next_work[63:56] & ~(8'hFF >> next_total[2:0]);
				held_q    <= next_total[2:0];
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q  <= load_work;
			total_q <= load_total;
			fill_q  <= load_fill;
		end else if (emit) begin
			work_q  <= next_work;
			total_q <= next_total;
		end
		if (emit) begin
			out_byte_q <= work_q[63:56];
			last_q     <= next_last;
		end
	end

endmodule

>>> sv/pc_trace_bit_packer_unit.sv
// Program-counter trace bit packer, MSB-first byte stream.
// Input channel (in_valid/in_stall): command, symbol_code, payload_value,
// first_count; a transfer happens when in_valid is high and in_stall low.
// Start emits a 16-byte header, a symbol appends 3 code bits plus 0/16/31
// payload bits, stop flushes a partial byte padded with zeros.
// Output channel (out_valid/out_stall): one byte per transfer, last_of_run
// marks the final byte caused by an item.
// Config channel (cfg_valid/cfg_ready): payload length table, always ready;
// write only while idle.
// Items go through a QUEUE_DEPTH-entry queue; the back end loads an item
// into its byte shifter, then shifts its bytes out in order and takes no
// new item until the last byte has left the shifter. The shifter is the limit.
// Bytes pass the queue, the shifter and then the output byte register.
// While out_stall is high the output byte holds and the shifter waits;
// the queue keeps taking items until full, then in_stall rises.
// Reset clears the bit buffer, the queue and the table to its default.
module pc_trace_bit_packer_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  symbol_code,
	input  logic [30:0] payload_value,
	input  logic [63:0] first_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);
	import pcbp_pkg::*;

	op_t  push_op;
	op_t  pop_op;
	logic push;
	logic pop;
	logic not_full;
	logic not_empty;

	pcbp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.symbol_code   (symbol_code),
		.payload_value (payload_value),
		.first_count   (first_count),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.q_not_full    (not_full),
		.q_push        (push),
		.q_op          (push_op)
	);

	pcbp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.not_full  (not_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_op    (pop_op)
	);

	pcbp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (not_empty),
		.q_op        (pop_op),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

>>> sv/pcbp_checker.sv
`include "pc_trace_bit_packer_unit_defines.svh"

module pcbp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       cfg_ready,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last_of_run
);

	// stalled output holds
	`PCBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_byte) && $stable(last_of_run))

	// a run keeps streaming: a non-final byte is followed at once by another
	`PCBP_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !last_of_run, out_valid)

	// table register never back-pressures
	`PCBP_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

	// input stall is always resolved while a transfer is offered
	`PCBP_ASSERT_NOW(a_in_stall_known, in_valid, !$isunknown(in_stall))

endmodule

bind pc_trace_bit_packer_unit pcbp_checker u_pcbp_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import pcbp_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 48;

	class byte_stream_model;
		logic [15:0] length_table;
		logic [7:0]  partial_byte;
		int          bits_held;
		logic [7:0]  run_bytes[$];
		logic [8:0]  expected_bytes[$];
		int          errors;

		function new();
			length_table = TABLE_RESET;
			partial_byte = '0;
			bits_held = 0;
			errors = 0;
		endfunction

		function void shift_in(int nbits, logic [63:0] value);
			for (int i = nbits; i > 0; i--) begin
				partial_byte = {partial_byte[6:0], value[i-1]};
				bits_held++;
				if (bits_held == 8) begin
					run_bytes.push_back(partial_byte);
					partial_byte = '0;
					bits_held = 0;
				end
			end
		endfunction

		// predicted bytes of one accepted item, last flag on the final one
		function void note_item(logic [1:0] cmd, logic [2:0] code, logic [30:0] pay,
				logic [63:0] first);
			logic [1:0] len_kind;
			run_bytes.delete();
			case (cmd)
				CMD_START: begin
					partial_byte = '0;
					bits_held = 0;
					shift_in(64, first);
					shift_in(64, '1);
				end
				CMD_SYM: begin
					len_kind = length_table[code*2 +: 2];
					shift_in(3, {61'd0, code});
					if (len_kind == LEN_16)
						shift_in(16, {33'd0, pay});
					else if (len_kind == LEN_31)
						shift_in(31, {33'd0, pay});
				end
				CMD_STOP: begin
					if (bits_held > 0) begin
						run_bytes.push_back(partial_byte << (8 - bits_held));
						partial_byte = '0;
						bits_held = 0;
					end
				end
				default: ;
			endcase
			for (int i = 0; i < run_bytes.size(); i++)
				expected_bytes.push_back({run_bytes[i], i == run_bytes.size() - 1});
		endfunction

		function void check_byte(logic [7:0] got_byte, logic got_last);
			logic [8:0] want;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte %02h last %0d", $time, got_byte, got_last);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				if (got_byte !== want[8:1]) begin
					$display("%0t: out_byte expected %02h, got %02h", $time, want[8:1], got_byte);
					errors++;
				end
				if (got_last !== want[0]) begin
					$display("%0t: last_of_run expected %0d, got %0d", $time, want[0], got_last);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [2:0]  symbol_code;
	logic [30:0] payload_value;
	logic [63:0] first_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last_of_run;

	byte_stream_model packer = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	pc_trace_bit_packer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.symbol_code(symbol_code),
		.payload_value(payload_value),
		.first_count(first_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_of_run(last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// outputs are stable mid-cycle; a transfer seen here completes at the next rising edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			packer.check_byte(out_byte, last_of_run);
	end

	task automatic send_item(logic [1:0] cmd, logic [2:0] code, logic [30:0] pay,
			logic [63:0] first);
		logic taken;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		symbol_code <= code;
		payload_value <= pay;
		first_count <= first;
		do begin
			@(negedge clk);
			taken = !in_stall;
			if (taken)
				packer.note_item(cmd, code, pay, first);
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (packer.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_length_table(logic [15:0] value);
		logic taken;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		packer.length_table = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [30:0] pick_payload();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic run_random(int n_items);
		int sel;
		logic [1:0] cmd;
		logic [63:0] first;
		for (int i = 0; i < n_items; ) begin
			sel = $urandom_range(0, 99);
			if (sel < 8)
				cmd = CMD_START;
			else if (sel < 80)
				cmd = CMD_SYM;
			else if (sel < 93)
				cmd = CMD_STOP;
			else
				cmd = CMD_NONE;
			case ($urandom_range(0, 7))
				0: first = '0;
				1: first = '1;
				default: first = {$urandom, $urandom};
			endcase
			send_item(cmd, 3'($urandom_range(0, 7)), pick_payload(), first);
			if (cmd != CMD_NONE)
				i++;
		end
	endtask

	initial begin
		logic [15:0] phase_tables[6];
		int idle_sets[4][2];
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_NONE;
		symbol_code = '0;
		payload_value = '0;
		first_count = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		phase_tables = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0000, 16'h0000};
		phase_tables[4] = 16'($urandom);
		phase_tables[5] = 16'($urandom);
		idle_sets = '{'{0, 0}, '{79, 0}, '{0, 79}, '{35, 35}};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset table: codes 5,6 sixteen bits, 7 thirty-one bits
		send_item(CMD_START, 3'd0, '0, 64'd0);
		send_item(CMD_SYM, 3'd0, '0, '0);
		send_item(CMD_SYM, 3'd5, '1, '0);
		send_item(CMD_SYM, 3'd7, '1, '0);
		send_item(CMD_SYM, 3'd6, '0, '0);
		send_item(CMD_STOP, 3'd0, '0, '0);
		send_item(CMD_STOP, 3'd7, '1, '1);
		send_item(CMD_NONE, 3'd7, '1, '1);
		send_item(CMD_START, 3'd7, '1, '1);
		send_item(CMD_SYM, 3'd7, '0, '0);
		for (int c = 1; c <= 4; c++)
			send_item(CMD_SYM, 3'(c), '1, '1);
		// start while bits are held
		send_item(CMD_START, 3'd0, '0, 64'h0123_4567_89AB_CDEF);
		send_item(CMD_SYM, 3'd3, 31'h5555_5555, '0);
		send_item(CMD_SYM, 3'd2, 31'h2AAA_AAAA, '0);
		send_item(CMD_STOP, 3'd0, '0, '0);
		// table entry three means no payload
		write_length_table(16'hFFFF);
		send_item(CMD_SYM, 3'd4, '1, '0);
		send_item(CMD_SYM, 3'd7, '1, '0);
		send_item(CMD_STOP, 3'd0, '0, '0);
		write_length_table(16'h2468);
		send_item(CMD_SYM, 3'd1, 31'h7FFF_0000, '0);
		send_item(CMD_SYM, 3'd2, 31'h0000_FFFF, '0);
		send_item(CMD_STOP, 3'd0, '0, '0);

		for (int p = 0; p < 6; p++) begin
			write_length_table(phase_tables[p]);
			send_idle_pct = idle_sets[p % 4][0];
			stall_pct = idle_sets[p % 4][1];
			run_random(72);
		end

		send_idle_pct = 0;
		wait_drained();
		stall_pct = 0;
		if (packer.expected_bytes.size() != 0)
			$display("%0t: %0d expected bytes never arrived", $time,
				packer.expected_bytes.size());
		if (packer.errors == 0 && packer.expected_bytes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
